// File: rtl/core/isi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isi_pkg;

    // Number format and geometry
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int AXES        = 3;
    localparam int AXIS_W      = $clog2(AXES);
    localparam int STEP_W      = FRAC_BITS + 1;
    localparam int LIMIT_W     = VALUE_WIDTH - 1;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int QUOT_W      = PROD_W - FRAC_BITS;
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    // Input item fields
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_TICK     = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_LOAD_ROW = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_LOAD_PF  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_LOAD_IF  = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_LOAD_POS = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_LOAD_VEL = CMD_W'(5);

    // Mode register codes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_HOLD     = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_FOH      = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MODEL    = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_HOLD_ALT = MODE_W'(3);

    // Register file
    localparam int APB_DATA_W = 32;
    localparam int REG_COUNT  = 8;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int ADDR_W     = $clog2(REG_COUNT * 4);
    localparam logic [REG_IDX_W-1:0] REG_MODE        = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_STEP_H      = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_POS_LIMIT_X = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_POS_LIMIT_Y = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_POS_LIMIT_Z = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_VEL_LIMIT_X = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_VEL_LIMIT_Y = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_VEL_LIMIT_Z = REG_IDX_W'(7);
    localparam logic [STEP_W-1:0]    STEP_H_RESET    = STEP_W'(66);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified operation handed to the back end
    typedef enum logic [3:0] {
        OP_HOLD,
        OP_FOH,
        OP_MODEL,
        OP_LOAD_ROW,
        OP_LOAD_PF,
        OP_LOAD_IF,
        OP_LOAD_POS,
        OP_LOAD_VEL
    } op_t;

    typedef struct packed {
        op_t                                op;
        logic [AXIS_W-1:0]                  row;
        logic [AXES-1:0][VALUE_WIDTH-1:0]   vals;
    } item_t;

    typedef struct packed {
        logic [STEP_W-1:0]                  step_h;
        logic [AXES-1:0][LIMIT_W-1:0]       pos_limit;
        logic [AXES-1:0][LIMIT_W-1:0]       vel_limit;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/isi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module isi_front (
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [isi_pkg::CMD_W-1:0]              s_command,
    input  wire logic [isi_pkg::AXIS_W-1:0]             s_row_index,
    input  wire logic signed [isi_pkg::VALUE_WIDTH-1:0] s_value_a,
    input  wire logic signed [isi_pkg::VALUE_WIDTH-1:0] s_value_b,
    input  wire logic signed [isi_pkg::VALUE_WIDTH-1:0] s_value_c,
    input  wire logic [isi_pkg::MODE_W-1:0]             mode,
    output logic                                        q_push,
    output isi_pkg::item_t                              q_item,
    input  wire logic                                   q_full
);

    // Take an item whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the command; ticks resolve the mode here
    always_comb begin
        q_item.row     = s_row_index;
        q_item.vals[0] = s_value_a;
        q_item.vals[1] = s_value_b;
        q_item.vals[2] = s_value_c;
        q_item.op      = isi_pkg::OP_HOLD;
        case (s_command)
            isi_pkg::CMD_TICK: begin
                case (mode)
                    isi_pkg::MODE_FOH:   q_item.op = isi_pkg::OP_FOH;
                    isi_pkg::MODE_MODEL: q_item.op = isi_pkg::OP_MODEL;
                    default:             q_item.op = isi_pkg::OP_HOLD;
                endcase
            end
            isi_pkg::CMD_LOAD_ROW: begin
                // row three is dropped: the item only reports the state
                if (s_row_index <= isi_pkg::LAST_AXIS) begin
                    q_item.op = isi_pkg::OP_LOAD_ROW;
                end
            end
            isi_pkg::CMD_LOAD_PF:  q_item.op = isi_pkg::OP_LOAD_PF;
            isi_pkg::CMD_LOAD_IF:  q_item.op = isi_pkg::OP_LOAD_IF;
            isi_pkg::CMD_LOAD_POS: q_item.op = isi_pkg::OP_LOAD_POS;
            isi_pkg::CMD_LOAD_VEL: q_item.op = isi_pkg::OP_LOAD_VEL;
            default:               q_item.op = isi_pkg::OP_HOLD;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/isi_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module isi_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  isi_pkg::item_t      push_item,
    output logic                full,
    input  wire logic           pop,
    output isi_pkg::item_t      pop_item,
    output logic                empty
);

    isi_pkg::item_t                     slot_reg [isi_pkg::QUEUE_DEPTH];
    logic [isi_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [isi_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [isi_pkg::QUEUE_CNT_W-1:0]    count_reg;

    assign full     = (count_reg == isi_pkg::QUEUE_CNT_W'(isi_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    function automatic logic [isi_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [isi_pkg::QUEUE_PTR_W-1:0] p
    );
        if (p == isi_pkg::QUEUE_PTR_W'(isi_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + isi_pkg::QUEUE_PTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + isi_pkg::QUEUE_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - isi_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

    // Item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg < isi_pkg::QUEUE_CNT_W'(isi_pkg::QUEUE_DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// File: rtl/core/isi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module isi_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  isi_pkg::cfg_t                               cfg,
    input  isi_pkg::item_t                              q_item,
    input  wire logic                                   q_empty,
    output logic                                        q_pop,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_pos_x,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_pos_y,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_pos_z,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_vel_x,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_vel_y,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_vel_z
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FSUM,
        ST_MUL,
        ST_RND,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_ROW,
        PH_VEL,
        PH_POS
    } phase_t;

    // Architectural state
    logic signed [isi_pkg::VALUE_WIDTH-1:0] pos_reg  [isi_pkg::AXES];
    logic signed [isi_pkg::VALUE_WIDTH-1:0] vel_reg  [isi_pkg::AXES];
    logic signed [isi_pkg::VALUE_WIDTH-1:0] pf_reg   [isi_pkg::AXES];
    logic signed [isi_pkg::VALUE_WIDTH-1:0] if_reg   [isi_pkg::AXES];
    logic signed [isi_pkg::VALUE_WIDTH-1:0] mass_reg [isi_pkg::AXES][isi_pkg::AXES];

    // Sequencer and datapath
    state_t                                 state_reg;
    phase_t                                 phase_reg;
    isi_pkg::op_t                           op_reg;
    logic [isi_pkg::AXIS_W-1:0]             row_reg;
    logic [isi_pkg::AXIS_W-1:0]             col_reg;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] fsum_reg [isi_pkg::AXES];
    logic signed [isi_pkg::VALUE_WIDTH-1:0] acc_reg;
    logic [isi_pkg::PROD_W-1:0]             prod_reg;
    logic                                   neg_reg;
    logic [isi_pkg::VALUE_WIDTH-1:0]        term_reg;

    // Result register
    logic                                   m_valid_reg;
    logic                                   m_valid_next;
    logic                                   issue_now;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] out_pos_reg [isi_pkg::AXES];
    logic signed [isi_pkg::VALUE_WIDTH-1:0] out_vel_reg [isi_pkg::AXES];

    logic                                   out_free;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] op_a;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] op_b;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] base;
    logic                                   clamp_en;
    logic [isi_pkg::LIMIT_W-1:0]            clamp_lim;
    logic [isi_pkg::VALUE_WIDTH-1:0]        mag_a;
    logic [isi_pkg::VALUE_WIDTH-1:0]        mag_b;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] step_h_val;
    logic [isi_pkg::PROD_W-1:0]             rounded;
    logic [isi_pkg::QUOT_W-1:0]             quot;
    logic [isi_pkg::VALUE_WIDTH-1:0]        cap;
    logic [isi_pkg::VALUE_WIDTH-1:0]        qsat;
    logic [isi_pkg::VALUE_WIDTH-1:0]        term_next;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] sum_sat;
    logic signed [isi_pkg::VALUE_WIDTH:0]   sum_wide;
    logic signed [isi_pkg::VALUE_WIDTH:0]   lim_wide;
    logic signed [isi_pkg::VALUE_WIDTH:0]   lim_neg_wide;
    logic signed [isi_pkg::VALUE_WIDTH-1:0] acc_result;

    // Saturating add to the value range
    function automatic logic signed [isi_pkg::VALUE_WIDTH-1:0] sat_add(
        input logic signed [isi_pkg::VALUE_WIDTH-1:0] a,
        input logic signed [isi_pkg::VALUE_WIDTH-1:0] b
    );
        logic [isi_pkg::VALUE_WIDTH:0] s;
        s = {a[isi_pkg::VALUE_WIDTH-1], a} + {b[isi_pkg::VALUE_WIDTH-1], b};
        if (s[isi_pkg::VALUE_WIDTH] != s[isi_pkg::VALUE_WIDTH-1]) begin
            return {s[isi_pkg::VALUE_WIDTH], {(isi_pkg::VALUE_WIDTH-1){~s[isi_pkg::VALUE_WIDTH]}}};
        end
        return s[isi_pkg::VALUE_WIDTH-1:0];
    endfunction

    function automatic logic in_limit(
        input logic [isi_pkg::VALUE_WIDTH-1:0] v,
        input logic [isi_pkg::LIMIT_W-1:0]     lim
    );
        logic signed [isi_pkg::VALUE_WIDTH:0] vw;
        logic signed [isi_pkg::VALUE_WIDTH:0] lw;
        vw = {v[isi_pkg::VALUE_WIDTH-1], v};
        lw = {2'b00, lim};
        return (vw <= lw) && (vw >= -lw);
    endfunction

    assign out_free   = !m_valid_reg || m_ready;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign step_h_val = $signed({{(isi_pkg::VALUE_WIDTH-isi_pkg::STEP_W){1'b0}}, cfg.step_h});

    // Result valid: set by an item that needs no sequencing or a finished tick, cleared when taken
    assign issue_now = q_pop && q_item.op != isi_pkg::OP_FOH && q_item.op != isi_pkg::OP_MODEL;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (issue_now || (state_reg == ST_DONE && out_free)) begin
            m_valid_next = 1'b1;
        end
    end

    // Operand selection for the current product
    always_comb begin
        op_a      = '0;
        op_b      = '0;
        base      = '0;
        clamp_en  = 1'b0;
        clamp_lim = '0;
        case (phase_reg)
            PH_ROW: begin
                op_a = mass_reg[row_reg][col_reg];
                op_b = fsum_reg[col_reg];
                base = (col_reg == '0) ? '0 : acc_reg;
            end
            PH_VEL: begin
                op_a      = step_h_val;
                op_b      = acc_reg;
                base      = vel_reg[row_reg];
                clamp_en  = 1'b1;
                clamp_lim = cfg.vel_limit[row_reg];
            end
            PH_POS: begin
                op_a      = step_h_val;
                op_b      = vel_reg[row_reg];
                base      = pos_reg[row_reg];
                clamp_en  = (op_reg == isi_pkg::OP_MODEL);
                clamp_lim = cfg.pos_limit[row_reg];
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    // Magnitudes feed an unsigned multiplier; sign is kept aside
    assign mag_a = op_a[isi_pkg::VALUE_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[isi_pkg::VALUE_WIDTH-1] ? (~op_b + 1'b1) : op_b;

    // Round half away from zero on the magnitude, drop fraction, saturate
    always_comb begin
        rounded = prod_reg + (isi_pkg::PROD_W'(1) << (isi_pkg::FRAC_BITS - 1));
        quot    = rounded[isi_pkg::PROD_W-1:isi_pkg::FRAC_BITS];
        cap     = neg_reg ? {1'b1, {(isi_pkg::VALUE_WIDTH-1){1'b0}}}
                          : {1'b0, {(isi_pkg::VALUE_WIDTH-1){1'b1}}};
        qsat    = (quot > isi_pkg::QUOT_W'(cap)) ? cap : quot[isi_pkg::VALUE_WIDTH-1:0];
        term_next = neg_reg ? (~qsat + 1'b1) : qsat;
    end

    // Saturating accumulate, then the optional magnitude clamp
    always_comb begin
        sum_sat      = sat_add(base, $signed(term_reg));
        sum_wide     = {sum_sat[isi_pkg::VALUE_WIDTH-1], sum_sat};
        lim_wide     = {2'b00, clamp_lim};
        lim_neg_wide = -lim_wide;
        acc_result   = sum_sat;
        if (clamp_en) begin
            if (sum_wide > lim_wide) begin
                acc_result = lim_wide[isi_pkg::VALUE_WIDTH-1:0];
            end else if (sum_wide < lim_neg_wide) begin
                acc_result = lim_neg_wide[isi_pkg::VALUE_WIDTH-1:0];
            end
        end
    end

    // Sequencer, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_ROW;
            op_reg      <= isi_pkg::OP_HOLD;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            for (int k = 0; k < isi_pkg::AXES; k++) begin
                pos_reg[k]     <= '0;
                vel_reg[k]     <= '0;
                pf_reg[k]      <= '0;
                if_reg[k]      <= '0;
                fsum_reg[k]    <= '0;
                out_pos_reg[k] <= '0;
                out_vel_reg[k] <= '0;
                for (int j = 0; j < isi_pkg::AXES; j++) begin
                    mass_reg[k][j] <= '0;
                end
            end
        end else begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        op_reg <= q_item.op;
                        case (q_item.op)
                            isi_pkg::OP_FOH: begin
                                phase_reg <= PH_POS;
                                row_reg   <= '0;
                                state_reg <= ST_MUL;
                            end
                            isi_pkg::OP_MODEL: begin
                                state_reg <= ST_FSUM;
                            end
                            isi_pkg::OP_LOAD_ROW: begin
                                for (int j = 0; j < isi_pkg::AXES; j++) begin
                                    mass_reg[q_item.row][j] <= q_item.vals[j];
                                end
                            end
                            isi_pkg::OP_LOAD_PF: begin
                                for (int k = 0; k < isi_pkg::AXES; k++) begin
                                    pf_reg[k] <= q_item.vals[k];
                                end
                            end
                            isi_pkg::OP_LOAD_IF: begin
                                for (int k = 0; k < isi_pkg::AXES; k++) begin
                                    if_reg[k] <= q_item.vals[k];
                                end
                            end
                            isi_pkg::OP_LOAD_POS: begin
                                for (int k = 0; k < isi_pkg::AXES; k++) begin
                                    pos_reg[k] <= q_item.vals[k];
                                end
                            end
                            isi_pkg::OP_LOAD_VEL: begin
                                for (int k = 0; k < isi_pkg::AXES; k++) begin
                                    vel_reg[k] <= q_item.vals[k];
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                        // items that need no sequencing report at once
                        if (issue_now) begin
                            for (int k = 0; k < isi_pkg::AXES; k++) begin
                                out_pos_reg[k] <= (q_item.op == isi_pkg::OP_LOAD_POS) ?
                                                  q_item.vals[k] : pos_reg[k];
                                out_vel_reg[k] <= (q_item.op == isi_pkg::OP_LOAD_VEL) ?
                                                  q_item.vals[k] : vel_reg[k];
                            end
                        end
                    end
                end
                ST_FSUM: begin
                    for (int k = 0; k < isi_pkg::AXES; k++) begin
                        fsum_reg[k] <= sat_add(pf_reg[k], if_reg[k]);
                    end
                    phase_reg <= PH_ROW;
                    row_reg   <= '0;
                    col_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= mag_a * mag_b;
                    neg_reg   <= op_a[isi_pkg::VALUE_WIDTH-1] ^ op_b[isi_pkg::VALUE_WIDTH-1];
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    term_reg  <= term_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    case (phase_reg)
                        PH_ROW: begin
                            acc_reg   <= acc_result;
                            state_reg <= ST_MUL;
                            if (col_reg == isi_pkg::LAST_AXIS) begin
                                phase_reg <= PH_VEL;
                            end else begin
                                col_reg <= col_reg + isi_pkg::AXIS_W'(1);
                            end
                        end
                        PH_VEL: begin
                            vel_reg[row_reg] <= acc_result;
                            state_reg        <= ST_MUL;
                            col_reg          <= '0;
                            if (row_reg == isi_pkg::LAST_AXIS) begin
                                phase_reg <= PH_POS;
                                row_reg   <= '0;
                            end else begin
                                phase_reg <= PH_ROW;
                                row_reg   <= row_reg + isi_pkg::AXIS_W'(1);
                            end
                        end
                        PH_POS: begin
                            pos_reg[row_reg] <= acc_result;
                            if (row_reg == isi_pkg::LAST_AXIS) begin
                                state_reg <= ST_DONE;
                            end else begin
                                row_reg   <= row_reg + isi_pkg::AXIS_W'(1);
                                state_reg <= ST_MUL;
                            end
                        end
                        default: begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_DONE: begin
                    if (out_free) begin
                        for (int k = 0; k < isi_pkg::AXES; k++) begin
                            out_pos_reg[k] <= pos_reg[k];
                            out_vel_reg[k] <= vel_reg[k];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pos_x = out_pos_reg[0];
    assign m_pos_y = out_pos_reg[1];
    assign m_pos_z = out_pos_reg[2];
    assign m_vel_x = out_vel_reg[0];
    assign m_vel_y = out_vel_reg[1];
    assign m_vel_z = out_vel_reg[2];

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> row_reg <= isi_pkg::LAST_AXIS && col_reg <= isi_pkg::LAST_AXIS)
        else $error("row or column index out of range");

    a_done_only_for_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> op_reg == isi_pkg::OP_FOH || op_reg == isi_pkg::OP_MODEL)
        else $error("sequencer finished an item that needs no sequencing");

    a_vel_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && op_reg == isi_pkg::OP_MODEL |->
            in_limit(vel_reg[0], cfg.vel_limit[0]) && in_limit(vel_reg[1], cfg.vel_limit[1])
            && in_limit(vel_reg[2], cfg.vel_limit[2]))
        else $error("velocity beyond its limit after a model tick");

endmodule

`default_nettype wire

// File: rtl/core/interface_state_integrator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Interface state integrator: 3-axis position/velocity in signed Q16.16.
// Input channel (s_valid/s_ready) carries command items: ticks, matrix row,
// force, position and velocity loads. Every accepted item yields exactly one
// item on the result channel (m_valid/m_ready): position and velocity after it.
// The APB port sets mode, step h and the clamp limits; write it only when idle.
// A front end classifies items into a two-entry queue; the back end executes.
// Loads, hold ticks and unused commands need no sequencing, so they stream at
// one item per cycle while no tick runs and the receiver takes results; m_valid
// rises once the item has passed the queue and the result register. Ticks run
// on one shared multiply / round / accumulate unit, one product at a time: a
// first-order tick takes 3 products, a model tick 15 products plus force sum.
// Reset (aresetn low, synchronous) zeroes the integrator state, loads register
// defaults (step h 66, limits full scale). A stalled receiver holds the result
// register; the back end waits and the queue keeps accepting until it fills.

module interface_state_integrator_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [isi_pkg::CMD_W-1:0]              s_command,
    input  wire logic [isi_pkg::AXIS_W-1:0]             s_row_index,
    input  wire logic signed [isi_pkg::VALUE_WIDTH-1:0] s_value_a,
    input  wire logic signed [isi_pkg::VALUE_WIDTH-1:0] s_value_b,
    input  wire logic signed [isi_pkg::VALUE_WIDTH-1:0] s_value_c,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_pos_x,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_pos_y,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_pos_z,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_vel_x,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_vel_y,
    output logic signed [isi_pkg::VALUE_WIDTH-1:0]      m_vel_z,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [isi_pkg::ADDR_W-1:0]             paddr,
    input  wire logic [isi_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [isi_pkg::APB_DATA_W-1:0]              prdata,
    output logic                                        pready
);

    logic [isi_pkg::MODE_W-1:0]         mode_reg;
    logic [isi_pkg::STEP_W-1:0]         step_h_reg;
    logic [isi_pkg::LIMIT_W-1:0]        pos_limit_reg [isi_pkg::AXES];
    logic [isi_pkg::LIMIT_W-1:0]        vel_limit_reg [isi_pkg::AXES];
    logic [isi_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                               reg_write;
    isi_pkg::cfg_t                      cfg;

    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_empty;
    isi_pkg::item_t                     push_item;
    isi_pkg::item_t                     pop_item;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[isi_pkg::ADDR_W-1:2];
    assign reg_write = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= isi_pkg::MODE_HOLD;
            step_h_reg <= isi_pkg::STEP_H_RESET;
            for (int k = 0; k < isi_pkg::AXES; k++) begin
                pos_limit_reg[k] <= '1;
                vel_limit_reg[k] <= '1;
            end
        end else if (reg_write) begin
            case (reg_idx)
                isi_pkg::REG_MODE:        mode_reg         <= pwdata[isi_pkg::MODE_W-1:0];
                isi_pkg::REG_STEP_H:      step_h_reg       <= pwdata[isi_pkg::STEP_W-1:0];
                isi_pkg::REG_POS_LIMIT_X: pos_limit_reg[0] <= pwdata[isi_pkg::LIMIT_W-1:0];
                isi_pkg::REG_POS_LIMIT_Y: pos_limit_reg[1] <= pwdata[isi_pkg::LIMIT_W-1:0];
                isi_pkg::REG_POS_LIMIT_Z: pos_limit_reg[2] <= pwdata[isi_pkg::LIMIT_W-1:0];
                isi_pkg::REG_VEL_LIMIT_X: vel_limit_reg[0] <= pwdata[isi_pkg::LIMIT_W-1:0];
                isi_pkg::REG_VEL_LIMIT_Y: vel_limit_reg[1] <= pwdata[isi_pkg::LIMIT_W-1:0];
                isi_pkg::REG_VEL_LIMIT_Z: vel_limit_reg[2] <= pwdata[isi_pkg::LIMIT_W-1:0];
                default:                  mode_reg         <= mode_reg;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            isi_pkg::REG_MODE:        prdata = isi_pkg::APB_DATA_W'(mode_reg);
            isi_pkg::REG_STEP_H:      prdata = isi_pkg::APB_DATA_W'(step_h_reg);
            isi_pkg::REG_POS_LIMIT_X: prdata = isi_pkg::APB_DATA_W'(pos_limit_reg[0]);
            isi_pkg::REG_POS_LIMIT_Y: prdata = isi_pkg::APB_DATA_W'(pos_limit_reg[1]);
            isi_pkg::REG_POS_LIMIT_Z: prdata = isi_pkg::APB_DATA_W'(pos_limit_reg[2]);
            isi_pkg::REG_VEL_LIMIT_X: prdata = isi_pkg::APB_DATA_W'(vel_limit_reg[0]);
            isi_pkg::REG_VEL_LIMIT_Y: prdata = isi_pkg::APB_DATA_W'(vel_limit_reg[1]);
            isi_pkg::REG_VEL_LIMIT_Z: prdata = isi_pkg::APB_DATA_W'(vel_limit_reg[2]);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        cfg.step_h = step_h_reg;
        for (int k = 0; k < isi_pkg::AXES; k++) begin
            cfg.pos_limit[k] = pos_limit_reg[k];
            cfg.vel_limit[k] = vel_limit_reg[k];
        end
    end

    isi_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_row_index (s_row_index),
        .s_value_a   (s_value_a),
        .s_value_b   (s_value_b),
        .s_value_c   (s_value_c),
        .mode        (mode_reg),
        .q_push      (q_push),
        .q_item      (push_item),
        .q_full      (q_full)
    );

    isi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    isi_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_item  (pop_item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_pos_x (m_pos_x),
        .m_pos_y (m_pos_y),
        .m_pos_z (m_pos_z),
        .m_vel_x (m_vel_x),
        .m_vel_y (m_vel_y),
        .m_vel_z (m_vel_z)
    );

endmodule

`default_nettype wire

// File: tb/isi_state_checker.sv
`timescale 1ns / 1ps

// Watches both item channels and the register port, keeps its own copy of the
// integrator state and compares every result item with the oldest expectation.
module isi_state_checker
    import isi_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [CMD_W-1:0]        s_command,
    input  logic [AXIS_W-1:0]       s_row_index,
    input  logic [VALUE_WIDTH-1:0]  s_value_a,
    input  logic [VALUE_WIDTH-1:0]  s_value_b,
    input  logic [VALUE_WIDTH-1:0]  s_value_c,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [VALUE_WIDTH-1:0]  m_pos_x,
    input  logic [VALUE_WIDTH-1:0]  m_pos_y,
    input  logic [VALUE_WIDTH-1:0]  m_pos_z,
    input  logic [VALUE_WIDTH-1:0]  m_vel_x,
    input  logic [VALUE_WIDTH-1:0]  m_vel_y,
    input  logic [VALUE_WIDTH-1:0]  m_vel_z,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic                    pready,
    output int                      fail_count,
    output int                      outstanding
);

    localparam longint VAL_MAX = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    // one result item: pos x/y/z in slots 0..2, vel x/y/z in slots 3..5
    typedef logic [5:0][VALUE_WIDTH-1:0] state_word_t;

    // integrator state
    longint pos_st [AXES];
    longint vel_st [AXES];
    longint inv_mass_st [AXES*AXES];
    longint pred_force_st [AXES];
    longint contact_force_st [AXES];

    // register copy
    logic [MODE_W-1:0]  cfg_mode;
    logic [STEP_W-1:0]  cfg_step;
    logic [LIMIT_W-1:0] cfg_pos_lim [AXES];
    logic [LIMIT_W-1:0] cfg_vel_lim [AXES];

    state_word_t expected_states [$];
    string field_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

    function automatic longint sat_word(input longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        return sat_word(a + b);
    endfunction

    // exact product, round half away from zero on magnitude, drop fraction, saturate
    function automatic longint mul_round(input longint a, input longint b);
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] quot;
        logic        neg;
        neg   = (a < 0) != (b < 0);
        mag_a = (a < 0) ? 64'(-a) : 64'(a);
        mag_b = (b < 0) ? 64'(-b) : 64'(b);
        quot  = (mag_a * mag_b + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!neg) return (quot > 64'(VAL_MAX)) ? VAL_MAX : longint'(quot);
        if (quot > 64'(VAL_MAX)) return VAL_MIN;
        return -longint'(quot);
    endfunction

    function automatic longint clamp_mag(input longint v, input logic [LIMIT_W-1:0] lim);
        longint l;
        l = longint'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // apply one accepted item and queue the state it leaves behind
    task automatic advance_state(input logic [CMD_W-1:0] cmd, input logic [AXIS_W-1:0] row,
                                 input logic [VALUE_WIDTH-1:0] va,
                                 input logic [VALUE_WIDTH-1:0] vb,
                                 input logic [VALUE_WIDTH-1:0] vc);
        longint      vals [AXES];
        longint      force_sum [AXES];
        longint      accel;
        longint      h;
        state_word_t snap;
        int          i;
        int          j;
        vals[0] = longint'($signed(va));
        vals[1] = longint'($signed(vb));
        vals[2] = longint'($signed(vc));
        h = longint'(cfg_step);
        case (cmd)
            CMD_TICK: begin
                if (cfg_mode == MODE_FOH) begin
                    // position only, no clamp
                    for (i = 0; i < AXES; i++)
                        pos_st[i] = add_sat(pos_st[i], mul_round(h, vel_st[i]));
                end else if (cfg_mode == MODE_MODEL) begin
                    for (i = 0; i < AXES; i++)
                        force_sum[i] = add_sat(pred_force_st[i], contact_force_st[i]);
                    for (i = 0; i < AXES; i++) begin
                        accel = 0;
                        for (j = 0; j < AXES; j++)
                            accel = add_sat(accel,
                                            mul_round(inv_mass_st[i*AXES+j], force_sum[j]));
                        vel_st[i] = clamp_mag(add_sat(vel_st[i], mul_round(h, accel)),
                                              cfg_vel_lim[i]);
                    end
                    // position uses the freshly clamped velocity
                    for (i = 0; i < AXES; i++)
                        pos_st[i] = clamp_mag(add_sat(pos_st[i], mul_round(h, vel_st[i])),
                                              cfg_pos_lim[i]);
                end
            end
            CMD_LOAD_ROW: begin
                if (row <= LAST_AXIS)
                    for (j = 0; j < AXES; j++) inv_mass_st[int'(row)*AXES+j] = vals[j];
            end
            CMD_LOAD_PF:  pred_force_st = vals;
            CMD_LOAD_IF:  contact_force_st = vals;
            CMD_LOAD_POS: pos_st = vals;
            CMD_LOAD_VEL: vel_st = vals;
            default: ;
        endcase
        for (i = 0; i < AXES; i++) begin
            snap[i]        = VALUE_WIDTH'(pos_st[i]);
            snap[AXES + i] = VALUE_WIDTH'(vel_st[i]);
        end
        expected_states.insert(expected_states.size(), snap);
    endtask

    always @(posedge aclk) begin
        state_word_t got;
        state_word_t want;
        int          k;
        if (!aresetn) begin
            // reset state and register defaults
            for (k = 0; k < AXES; k++) begin
                pos_st[k]           = 0;
                vel_st[k]           = 0;
                pred_force_st[k]    = 0;
                contact_force_st[k] = 0;
                cfg_pos_lim[k]      = '1;
                cfg_vel_lim[k]      = '1;
            end
            for (k = 0; k < AXES*AXES; k++) inv_mass_st[k] = 0;
            cfg_mode = MODE_HOLD;
            cfg_step = STEP_H_RESET;
            expected_states.delete();
        end else begin
            // result side first: a result never belongs to an item taken at this edge
            if (m_valid && m_ready) begin
                got = {m_vel_z, m_vel_y, m_vel_x, m_pos_z, m_pos_y, m_pos_x};
                if (expected_states.size() == 0) begin
                    $error("unexpected result item: pos %0d %0d %0d vel %0d %0d %0d",
                           $signed(m_pos_x), $signed(m_pos_y), $signed(m_pos_z),
                           $signed(m_vel_x), $signed(m_vel_y), $signed(m_vel_z));
                    fail_count++;
                end else begin
                    want = expected_states.pop_front();
                    for (k = 0; k < 6; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("%s mismatch: expected %0d, got %0d", field_name[k],
                                   $signed(want[k]), $signed(got[k]));
                            fail_count++;
                        end
                    end
                end
            end
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_MODE:        cfg_mode = pwdata[MODE_W-1:0];
                    REG_STEP_H:      cfg_step = pwdata[STEP_W-1:0];
                    REG_POS_LIMIT_X: cfg_pos_lim[0] = pwdata[LIMIT_W-1:0];
                    REG_POS_LIMIT_Y: cfg_pos_lim[1] = pwdata[LIMIT_W-1:0];
                    REG_POS_LIMIT_Z: cfg_pos_lim[2] = pwdata[LIMIT_W-1:0];
                    REG_VEL_LIMIT_X: cfg_vel_lim[0] = pwdata[LIMIT_W-1:0];
                    REG_VEL_LIMIT_Y: cfg_vel_lim[1] = pwdata[LIMIT_W-1:0];
                    REG_VEL_LIMIT_Z: cfg_vel_lim[2] = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                advance_state(s_command, s_row_index, s_value_a, s_value_b, s_value_c);
        end
        outstanding = expected_states.size();
    end

endmodule

// File: tb/interface_state_integrator_unit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the interface state integrator; checking lives in
// isi_state_checker.
module interface_state_integrator_unit_tb;
    import isi_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_SPARE_LO    = CMD_W'(6);
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI    = CMD_W'(7);
    localparam logic [AXIS_W-1:0] ROW_NONE        = AXIS_W'(3);
    localparam logic [31:0]       WORD_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0]       WORD_MIN        = 32'h8000_0000;
    localparam logic [31:0]       ONE_Q16         = 32'h0001_0000;
    localparam logic [31:0]       LIMIT_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0]       STEP_MAX        = 32'h0001_0000;
    localparam int                RANDOM_PHASES   = 8;
    localparam int                ITEMS_PER_PHASE = 50;
    localparam int                PRESSURE_PHASE  = 2;
    localparam int                LONG_HOLD       = 300;
    localparam int                SETTLE_CYCLES   = 8;
    localparam int                TAIL_CYCLES     = 100;
    localparam int                TIMEOUT_NS      = 2_000_000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command = CMD_TICK;
    logic [AXIS_W-1:0]      s_row_index = '0;
    logic signed [31:0]     s_value_a = '0;
    logic signed [31:0]     s_value_b = '0;
    logic signed [31:0]     s_value_c = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [31:0]     m_pos_x, m_pos_y, m_pos_z;
    logic signed [31:0]     m_vel_x, m_vel_y, m_vel_z;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;

    interface_state_integrator_unit DUT (.*);
    isi_state_checker u_state_check (.*);

    always #2 aclk = ~aclk;

    // hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("** interface_state_integrator_unit: FAILED **");
        $finish;
    end

    // receiver: decides at the rising edge, drives at the falling edge
    initial begin
        int  hold_left;
        logic ready_next;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(99) >= rx_stall_pct);
            end
            @(negedge aclk);
            m_ready <= ready_next;
        end
    end

    // register write: setup then access, starts on the next falling edge
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one item, return at the falling edge after it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [AXIS_W-1:0] row,
                             input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_row_index <= row;
        s_value_a   <= a;
        s_value_b   <= b;
        s_value_c   <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, AXIS_W'($urandom), $urandom, $urandom, $urandom);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // mostly small Q16.16 values, with full-range words and extremes mixed in
    function automatic logic [31:0] rand_word();
        int pick;
        int s;
        pick = $urandom_range(99);
        if (pick < 25) return $urandom;
        if (pick < 35) begin
            case ($urandom_range(4))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return 32'h0;
                3:       return 32'hFFFF_FFFF;
                default: return ONE_Q16;
            endcase
        end
        s = int'($urandom_range(524288)) - 262144;
        return s;
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(7))
            0:       return 32'h0;
            1, 2:    return LIMIT_MAX;
            3, 4:    return $urandom & LIMIT_MAX;
            default: return $urandom_range(32'h0008_0000);
        endcase
    endfunction

    // one item of any kind, including ignored rows and unused codes
    task automatic random_item();
        int pick;
        logic [AXIS_W-1:0] row;
        pick = $urandom_range(99);
        row  = ($urandom_range(15) == 0) ? ROW_NONE : AXIS_W'($urandom_range(2));
        if (pick < 40)      send_tick();
        else if (pick < 55) send_item(CMD_LOAD_ROW, row, rand_word(), rand_word(), rand_word());
        else if (pick < 65) send_item(CMD_LOAD_PF, AXIS_W'($urandom), rand_word(), rand_word(),
                                      rand_word());
        else if (pick < 75) send_item(CMD_LOAD_IF, AXIS_W'($urandom), rand_word(), rand_word(),
                                      rand_word());
        else if (pick < 83) send_item(CMD_LOAD_POS, AXIS_W'($urandom), rand_word(), rand_word(),
                                      rand_word());
        else if (pick < 91) send_item(CMD_LOAD_VEL, AXIS_W'($urandom), rand_word(), rand_word(),
                                      rand_word());
        else send_item($urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO, AXIS_W'($urandom),
                       $urandom, $urandom, $urandom);
    endtask

    // usually a full model set-up followed by a run of ticks, sometimes noise
    task automatic random_burst(inout int sent);
        int n_ticks;
        int r;
        if ($urandom_range(99) < 70) begin
            for (r = 0; r < AXES; r++)
                send_item(CMD_LOAD_ROW, AXIS_W'(r), rand_word(), rand_word(), rand_word());
            send_item(CMD_LOAD_PF, AXIS_W'($urandom), rand_word(), rand_word(), rand_word());
            send_item(CMD_LOAD_IF, AXIS_W'($urandom), rand_word(), rand_word(), rand_word());
            sent += 5;
            if ($urandom_range(1)) begin
                send_item(CMD_LOAD_VEL, AXIS_W'($urandom), rand_word(), rand_word(),
                          rand_word());
                sent++;
            end
            n_ticks = $urandom_range(2, 6);
            repeat (n_ticks) send_tick();
            sent += n_ticks;
        end else begin
            repeat (3) random_item();
            sent += 3;
        end
    endtask

    task automatic shuffle_config(input int phase);
        logic [MODE_W-1:0] mode;
        logic [31:0]       step;
        int                i;
        if (phase == 3)          mode = MODE_HOLD;
        else if (phase == 6)     mode = MODE_HOLD_ALT;
        else if (phase % 3 == 1) mode = MODE_FOH;
        else                     mode = MODE_MODEL;
        case ($urandom_range(3))
            0:       step = STEP_MAX;
            1:       step = $urandom_range(STEP_MAX, 1);
            2:       step = $urandom_range(2048);
            default: step = 32'(STEP_H_RESET);
        endcase
        apb_write(REG_MODE, 32'(mode));
        apb_write(REG_STEP_H, step);
        for (i = 0; i < AXES; i++) begin
            apb_write(REG_POS_LIMIT_X + REG_IDX_W'(i), rand_limit());
            apb_write(REG_VEL_LIMIT_X + REG_IDX_W'(i), rand_limit());
        end
    endtask

    task automatic set_idling(input int pattern);
        case (pattern)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 56; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 56; end
            default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
        endcase
    endtask

    initial begin
        int phase;
        int sent;
        int i;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: loads at the extremes, ignored row, unused codes, hold ticks
        send_tick();
        send_item(CMD_LOAD_POS, '0, WORD_MAX, WORD_MIN, 32'h0);
        send_item(CMD_LOAD_VEL, '0, WORD_MIN, WORD_MAX, ONE_Q16);
        send_item(CMD_LOAD_ROW, AXIS_W'(0), WORD_MAX, WORD_MIN, 32'h1);
        send_item(CMD_LOAD_ROW, AXIS_W'(1), 32'h0, 32'hFFFF_FFFF, ONE_Q16);
        send_item(CMD_LOAD_ROW, AXIS_W'(2), WORD_MIN, WORD_MAX, 32'hFFFF_0000);
        send_item(CMD_LOAD_ROW, ROW_NONE, 32'h1, 32'h2, 32'h3);
        send_item(CMD_LOAD_PF, '0, WORD_MAX, WORD_MIN, 32'h0002_0000);
        send_item(CMD_LOAD_IF, '0, WORD_MAX, WORD_MIN, 32'hFFFF_8000);
        send_item(CMD_SPARE_LO, AXIS_W'($urandom), $urandom, $urandom, $urandom);
        send_item(CMD_SPARE_HI, AXIS_W'($urandom), $urandom, $urandom, $urandom);
        send_tick();

        // first-order hold with a full unit step: position saturates, no clamp
        drain();
        apb_write(REG_MODE, 32'(MODE_FOH));
        apb_write(REG_STEP_H, STEP_MAX);
        send_tick();
        send_tick();

        // model mode against tight and open limits on each axis
        drain();
        apb_write(REG_MODE, 32'(MODE_MODEL));
        apb_write(REG_POS_LIMIT_X, 32'h0);
        apb_write(REG_POS_LIMIT_Y, 32'h0003_0000);
        apb_write(REG_POS_LIMIT_Z, LIMIT_MAX);
        apb_write(REG_VEL_LIMIT_X, LIMIT_MAX);
        apb_write(REG_VEL_LIMIT_Y, 32'h0);
        apb_write(REG_VEL_LIMIT_Z, 32'h0000_8000);
        send_tick();
        send_tick();

        // zero step, then the second hold code
        drain();
        apb_write(REG_STEP_H, 32'h0);
        send_tick();
        drain();
        apb_write(REG_MODE, 32'(MODE_HOLD_ALT));
        apb_write(REG_STEP_H, 32'(STEP_H_RESET));
        send_tick();

        // random phases over the settings and idling patterns
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            set_idling(phase % 4);
            shuffle_config(phase);
            if (phase == PRESSURE_PHASE) begin
                // receiver holds off while the sender keeps offering: input must stall
                tx_idle_pct = 0;
                rx_hold_req = LONG_HOLD;
                for (i = 0; i < 12; i++) random_item();
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) random_burst(sent);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("** interface_state_integrator_unit: PASSED **");
        end else begin
            $display("** interface_state_integrator_unit: FAILED **");
        end
        $finish;
    end

endmodule
